FILE: rtl/core/triangle_box_uv_projection_assert.svh
// ---------------------------------------------------------------------------
// triangle box uv projection assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_BOX_UV_PROJECTION_ASSERT_SVH
`define TRIANGLE_BOX_UV_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TBUVP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbuvp assertion failed");

// next-cycle implication
`define TBUVP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbuvp assertion failed");

`else

`define TBUVP_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define TBUVP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/tbuvp_pkg.sv
// ---------------------------------------------------------------------------
// tbuvp_pkg
// shared constants and types of the triangle box uv projection block
// ---------------------------------------------------------------------------
package tbuvp_pkg;

   // uv scale, unsigned Q0.16
   localparam int SCALE_WIDTH = 16;
   localparam int ROUND_BIAS  = 1 << (SCALE_WIDTH - 1);

   // register file
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_SCALE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_NEG  = 1'd1;
   localparam logic [SCALE_WIDTH-1:0]     INV_SCALE_RESET = 16'd1311;
   localparam logic                       RIGHT_NEG_RESET = 1'b1;

   // facing codes
   localparam int FACING_WIDTH = 2;
   typedef logic [FACING_WIDTH-1:0] facing_type;
   localparam facing_type FACING_UP      = 2'd0;
   localparam facing_type FACING_FORWARD = 2'd1;
   localparam facing_type FACING_RIGHT   = 2'd2;

   // pipeline stages
   localparam int STG_DIFF   = 0;
   localparam int STG_MUL    = 1;
   localparam int STG_CROSS  = 2;
   localparam int STG_ABS    = 3;
   localparam int STG_PICK   = 4;
   localparam int STG_SEL    = 5;
   localparam int STG_SCALE  = 6;
   localparam int STG_OUT    = 7;
   localparam int NUM_STAGES = 8;

endpackage

FILE: rtl/core/tbuvp_if.sv
// ---------------------------------------------------------------------------
// tbuvp interfaces
// triangle request, uv response and register write channels
// ---------------------------------------------------------------------------
interface tbuvp_req_if #(parameter int COORD_WIDTH = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   output ready);
endinterface

interface tbuvp_rsp_if import tbuvp_pkg::*; #(parameter int COORD_WIDTH = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_u;
   logic signed [COORD_WIDTH-1:0] a_v;
   logic signed [COORD_WIDTH-1:0] b_u;
   logic signed [COORD_WIDTH-1:0] b_v;
   logic signed [COORD_WIDTH-1:0] c_u;
   logic signed [COORD_WIDTH-1:0] c_v;
   facing_type                    facing;
   logic                          u_flipped;

   modport source (output valid, a_u, a_v, b_u, b_v, c_u, c_v, facing, u_flipped,
                   input ready);
   modport sink   (input valid, a_u, a_v, b_u, b_v, c_u, c_v, facing, u_flipped,
                   output ready);
endinterface

interface tbuvp_csr_if import tbuvp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [SCALE_WIDTH-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tbuvp_scale.sv
// ---------------------------------------------------------------------------
// tbuvp_scale
// one uv lane: multiply by the reciprocal scale, round, saturate
// ---------------------------------------------------------------------------
module tbuvp_scale import tbuvp_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          mul_en,
   input  logic                          out_en,
   input  logic signed [COORD_WIDTH:0]   coord,
   input  logic [SCALE_WIDTH-1:0]        inv_scale,
   output logic signed [COORD_WIDTH-1:0] result
);

   localparam int PW = COORD_WIDTH + SCALE_WIDTH + 2;
   localparam int QW = PW - SCALE_WIDTH;
   localparam logic signed [QW-1:0] Q_MAX = QW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [PW-1:0]          biased;
   logic signed [QW-1:0]          quot;
   logic signed [COORD_WIDTH-1:0] result_ff, result_in;

   assign prod_in = coord * $signed({1'b0, inv_scale});

   // round half up, then clamp to the coordinate range
   always_comb begin
      biased = prod_ff + PW'(ROUND_BIAS);
      quot   = QW'(biased >>> SCALE_WIDTH);
      if (quot > Q_MAX) begin
         result_in = Q_MAX[COORD_WIDTH-1:0];
      end else if (quot < Q_MIN) begin
         result_in = Q_MIN[COORD_WIDTH-1:0];
      end else begin
         result_in = quot[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (out_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: rtl/core/triangle_box_uv_projection.sv
// ---------------------------------------------------------------------------
// triangle_box_uv_projection
// pipeline stages diff, mul, cross, abs, pick, sel, scale and out lie between request and response
// throughput: one triangle per cycle; a stalled response holds only the
//   stages behind it, empty stages keep filling (ready ripples per stage)
// reset: pipeline valids cleared, inv_scale 1311, right_axis_negative 1
// ---------------------------------------------------------------------------
`include "triangle_box_uv_projection_assert.svh"

module triangle_box_uv_projection import tbuvp_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input logic         clock,
   input logic         reset,
   tbuvp_req_if.sink   req_bus,
   tbuvp_rsp_if.source rsp_bus,
   tbuvp_csr_if.sink   csr_bus
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PRW = 2 * DW;
   localparam int NW  = PRW + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;
   typedef logic signed [DW-1:0]  diff_type;
   typedef logic signed [PRW-1:0] prod_type;
   typedef logic signed [NW-1:0]  norm_type;
   typedef logic [NW-1:0]         mag_type;

   // configuration
   logic [SCALE_WIDTH-1:0] inv_scale_ff, inv_scale_in;
   logic                   right_neg_ff, right_neg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      inv_scale_in = inv_scale_ff;
      right_neg_in = right_neg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_INV_SCALE: inv_scale_in = csr_bus.data;
            CSR_RIGHT_NEG: right_neg_in = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff <= INV_SCALE_RESET;
         right_neg_ff <= RIGHT_NEG_RESET;
      end else begin
         inv_scale_ff <= inv_scale_in;
         right_neg_ff <= right_neg_in;
      end
   end

   // stage valids and per-stage load enables
   logic [NUM_STAGES-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = en[STG_DIFF];

   // vertices travel with the item up to the select stage
   vec_type  vtx_ff [STG_DIFF:STG_PICK][3];
   vec_type  vtx_in [3];
   diff_type e1_ff [3], e1_in [3];   // x, y, z of v1 - v0
   diff_type e2_ff [3], e2_in [3];   // x, y, z of v2 - v0
   prod_type prod_ff [6], prod_in [6];
   norm_type n_ff [3], n_in [3];
   mag_type  mag_ff [3], mag_in [3];
   logic     nx_neg_ff;
   facing_type facing_ff [STG_PICK:STG_OUT];
   logic       flip_ff [STG_PICK:STG_OUT];
   facing_type facing_in;
   logic       flip_in;
   logic       nx_nonzero, z_win, y_win;
   diff_type   u_src_ff [3], u_src_in [3];
   diff_type   v_src_ff [3], v_src_in [3];
   coord_type  sel_a, sel_b;

   // edge vectors
   always_comb begin
      vtx_in[0] = '{x: req_bus.a_x, y: req_bus.a_y, z: req_bus.a_z};
      vtx_in[1] = '{x: req_bus.b_x, y: req_bus.b_y, z: req_bus.b_z};
      vtx_in[2] = '{x: req_bus.c_x, y: req_bus.c_y, z: req_bus.c_z};
      e1_in[0]  = diff_type'(req_bus.b_x) - diff_type'(req_bus.a_x);
      e1_in[1]  = diff_type'(req_bus.b_y) - diff_type'(req_bus.a_y);
      e1_in[2]  = diff_type'(req_bus.b_z) - diff_type'(req_bus.a_z);
      e2_in[0]  = diff_type'(req_bus.c_x) - diff_type'(req_bus.a_x);
      e2_in[1]  = diff_type'(req_bus.c_y) - diff_type'(req_bus.a_y);
      e2_in[2]  = diff_type'(req_bus.c_z) - diff_type'(req_bus.a_z);
   end

   // cross product partial products
   always_comb begin
      prod_in[0] = e1_ff[1] * e2_ff[2];
      prod_in[1] = e1_ff[2] * e2_ff[1];
      prod_in[2] = e1_ff[2] * e2_ff[0];
      prod_in[3] = e1_ff[0] * e2_ff[2];
      prod_in[4] = e1_ff[0] * e2_ff[1];
      prod_in[5] = e1_ff[1] * e2_ff[0];
   end

   always_comb begin
      n_in[0] = norm_type'(prod_ff[0]) - norm_type'(prod_ff[1]);
      n_in[1] = norm_type'(prod_ff[2]) - norm_type'(prod_ff[3]);
      n_in[2] = norm_type'(prod_ff[4]) - norm_type'(prod_ff[5]);
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = n_ff[k][NW-1] ? mag_type'(-n_ff[k]) : mag_type'(n_ff[k]);
      end
   end

   // facing pick: right, then forward, then up; strict wins, up by default
   always_comb begin
      nx_nonzero = (mag_ff[0] != '0);
      z_win      = mag_ff[2] > mag_ff[0];
      y_win      = (mag_ff[1] > mag_ff[0]) && (mag_ff[1] > mag_ff[2]);
      if (y_win) begin
         facing_in = FACING_UP;
      end else if (z_win) begin
         facing_in = FACING_FORWARD;
      end else if (nx_nonzero) begin
         facing_in = FACING_RIGHT;
      end else begin
         facing_in = FACING_UP;
      end
      // flip sticks even when forward or up win later
      flip_in = right_neg_ff ? (nx_nonzero && !nx_neg_ff) : nx_neg_ff;
   end

   // projection select, negations folded in ahead of the multiply
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (facing_ff[STG_PICK])
            FACING_FORWARD: begin
               sel_a = vtx_ff[STG_PICK][i].z;
               sel_b = vtx_ff[STG_PICK][i].y;
            end
            FACING_UP: begin
               sel_a = vtx_ff[STG_PICK][i].x;
               sel_b = vtx_ff[STG_PICK][i].z;
            end
            default: begin
               sel_a = vtx_ff[STG_PICK][i].x;
               sel_b = vtx_ff[STG_PICK][i].y;
            end
         endcase
         u_src_in[i] = flip_ff[STG_PICK] ? -diff_type'(sel_a) : diff_type'(sel_a);
         v_src_in[i] = -diff_type'(sel_b);
      end
   end

   always_ff @(posedge clock) begin
      if (en[STG_DIFF]) begin
         vtx_ff[STG_DIFF] <= vtx_in;
         e1_ff            <= e1_in;
         e2_ff            <= e2_in;
      end
      for (int s = STG_MUL; s <= STG_PICK; s++) begin
         if (en[s]) begin
            vtx_ff[s] <= vtx_ff[s-1];
         end
      end
      if (en[STG_MUL]) begin
         prod_ff <= prod_in;
      end
      if (en[STG_CROSS]) begin
         n_ff <= n_in;
      end
      if (en[STG_ABS]) begin
         mag_ff    <= mag_in;
         nx_neg_ff <= n_ff[0][NW-1];
      end
      if (en[STG_PICK]) begin
         facing_ff[STG_PICK] <= facing_in;
         flip_ff[STG_PICK]   <= flip_in;
      end
      for (int s = STG_SEL; s <= STG_OUT; s++) begin
         if (en[s]) begin
            facing_ff[s] <= facing_ff[s-1];
            flip_ff[s]   <= flip_ff[s-1];
         end
      end
      if (en[STG_SEL]) begin
         u_src_ff <= u_src_in;
         v_src_ff <= v_src_in;
      end
   end

   // six scaling lanes: multiply stage, then round and saturate stage
   coord_type u_res [3];
   coord_type v_res [3];

   for (genvar g = 0; g < 3; g++) begin : g_lane
      tbuvp_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_u (
         .clock     (clock),
         .mul_en    (en[STG_SCALE]),
         .out_en    (en[STG_OUT]),
         .coord     (u_src_ff[g]),
         .inv_scale (inv_scale_ff),
         .result    (u_res[g])
      );
      tbuvp_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_v (
         .clock     (clock),
         .mul_en    (en[STG_SCALE]),
         .out_en    (en[STG_OUT]),
         .coord     (v_src_ff[g]),
         .inv_scale (inv_scale_ff),
         .result    (v_res[g])
      );
   end

   assign rsp_bus.valid     = vld_ff[STG_OUT];
   assign rsp_bus.a_u       = u_res[0];
   assign rsp_bus.a_v       = v_res[0];
   assign rsp_bus.b_u       = u_res[1];
   assign rsp_bus.b_v       = v_res[1];
   assign rsp_bus.c_u       = u_res[2];
   assign rsp_bus.c_v       = v_res[2];
   assign rsp_bus.facing    = facing_ff[STG_OUT];
   assign rsp_bus.u_flipped = flip_ff[STG_OUT];

   // checks
   logic in_fire, out_fire;
   assign in_fire  = req_bus.valid && req_bus.ready;
   assign out_fire = rsp_bus.valid && rsp_bus.ready;

   `TBUVP_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(vld_ff) == $past($countones(vld_ff)) + $past(32'(in_fire)) - $past(32'(out_fire)))
   `TBUVP_ASSERT_IMPLY(a_bubble_accepts, clock, reset, !(&vld_ff), req_bus.ready)
   `TBUVP_ASSERT_NEXT(a_flat_is_up, clock, reset, vld_ff[STG_ABS] && en[STG_PICK] && mag_ff[0] == '0 && mag_ff[1] == '0 && mag_ff[2] == '0, facing_ff[STG_PICK] == FACING_UP && !flip_ff[STG_PICK])

endmodule

FILE: tb/triangle_box_uv_projection_tb.sv
// ---------------------------------------------------------------------------
// triangle_box_uv_projection_tb
// streams triangles through the projection pipeline under several scale and
// right-axis settings; a scoreboard predicts the facing, the u flip and the
// six uv values of each request transaction and checks the responses in order
// ---------------------------------------------------------------------------
module triangle_box_uv_projection_tb import tbuvp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW         = 24;
   localparam int COORD_MAX  = 2 ** (CW - 1) - 1;
   localparam int COORD_MIN  = -(2 ** (CW - 1));
   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;
   localparam int AXIS_Z     = 2;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 113;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic signed [CW-1:0] coord_type;

   // c[vertex][axis]
   typedef struct {
      coord_type c[3][3];
   } triangle_type;

   typedef struct {
      coord_type  u[3];
      coord_type  v[3];
      facing_type facing;
      logic       u_flipped;
   } uv_result_type;

   class uv_scoreboard;
      logic [SCALE_WIDTH-1:0] inv_scale;
      bit                     right_neg;
      uv_result_type          expected_uv[$];
      int                     errors;

      function new();
         inv_scale = INV_SCALE_RESET;
         right_neg = RIGHT_NEG_RESET;
         errors    = 0;
      endfunction

      function int pending();
         return expected_uv.size();
      endfunction

      // exact product, optional negation, round half up, saturate
      function coord_type scale_coord(coord_type c, bit negate);
         longint prod;
         longint q;
         prod = longint'(c) * longint'({1'b0, inv_scale});
         if (negate)
            prod = -prod;
         q = (prod + ROUND_BIAS) >>> SCALE_WIDTH;
         if (q > COORD_MAX)
            q = COORD_MAX;
         if (q < COORD_MIN)
            q = COORD_MIN;
         return coord_type'(q);
      endfunction

      function uv_result_type project_triangle(triangle_type t);
         longint        s1[3];
         longint        s2[3];
         longint        nrm[3];
         longint        best;
         longint        tr;
         int            ia;
         int            ib;
         uv_result_type r;
         for (int k = 0; k < 3; k++) begin
            s1[k] = longint'(t.c[1][k]) - longint'(t.c[0][k]);
            s2[k] = longint'(t.c[2][k]) - longint'(t.c[0][k]);
         end
         nrm[AXIS_X] = s1[AXIS_Y] * s2[AXIS_Z] - s1[AXIS_Z] * s2[AXIS_Y];
         nrm[AXIS_Y] = s1[AXIS_Z] * s2[AXIS_X] - s1[AXIS_X] * s2[AXIS_Z];
         nrm[AXIS_Z] = s1[AXIS_X] * s2[AXIS_Y] - s1[AXIS_Y] * s2[AXIS_X];

         // right, forward, up; strictly larger wins, flip sticks once set
         r.facing    = FACING_UP;
         r.u_flipped = 1'b0;
         best        = 0;
         tr = right_neg ? -nrm[AXIS_X] : nrm[AXIS_X];
         if (tr > best) begin
            best     = tr;
            r.facing = FACING_RIGHT;
         end else if (-tr > best) begin
            best        = -tr;
            r.facing    = FACING_RIGHT;
            r.u_flipped = 1'b1;
         end
         if (nrm[AXIS_Z] > best) begin
            best     = nrm[AXIS_Z];
            r.facing = FACING_FORWARD;
         end else if (-nrm[AXIS_Z] > best) begin
            best     = -nrm[AXIS_Z];
            r.facing = FACING_FORWARD;
         end
         if (nrm[AXIS_Y] > best) begin
            best     = nrm[AXIS_Y];
            r.facing = FACING_UP;
         end else if (-nrm[AXIS_Y] > best) begin
            best     = -nrm[AXIS_Y];
            r.facing = FACING_UP;
         end

         case (r.facing)
            FACING_FORWARD: begin
               ia = AXIS_Z;
               ib = AXIS_Y;
            end
            FACING_UP: begin
               ia = AXIS_X;
               ib = AXIS_Z;
            end
            default: begin
               ia = AXIS_X;
               ib = AXIS_Y;
            end
         endcase
         for (int k = 0; k < 3; k++) begin
            r.u[k] = scale_coord(t.c[k][ia], r.u_flipped);
            r.v[k] = scale_coord(t.c[k][ib], 1'b1);
         end
         return r;
      endfunction

      function void note_triangle(triangle_type t);
         expected_uv = {expected_uv, project_triangle(t)};
      endfunction

      function void check_uv(uv_result_type got);
         uv_result_type exp;
         string         vname[3];
         vname = '{"a", "b", "c"};
         if (expected_uv.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         exp = expected_uv.pop_front();
         for (int k = 0; k < 3; k++) begin
            if (got.u[k] !== exp.u[k]) begin
               $error("%s_u: expected %0d, actual %0d", vname[k], exp.u[k], got.u[k]);
               errors++;
            end
            if (got.v[k] !== exp.v[k]) begin
               $error("%s_v: expected %0d, actual %0d", vname[k], exp.v[k], got.v[k]);
               errors++;
            end
         end
         if (got.facing !== exp.facing) begin
            $error("facing: expected %0d, actual %0d", exp.facing, got.facing);
            errors++;
         end
         if (got.u_flipped !== exp.u_flipped) begin
            $error("u_flipped: expected %0d, actual %0d", exp.u_flipped, got.u_flipped);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   long_hold;

   uv_scoreboard board = new();

   tbuvp_req_if #(.COORD_WIDTH(CW)) req_bus ();
   tbuvp_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();
   tbuvp_csr_if                     csr_bus ();

   triangle_box_uv_projection #(.COORD_WIDTH(CW)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("triangle_box_uv_projection_tb: errors");
         $finish;
      end
   end

   // transaction monitor
   always @(posedge clock) begin
      triangle_type  t;
      uv_result_type r;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            t.c[0] = '{req_bus.a_x, req_bus.a_y, req_bus.a_z};
            t.c[1] = '{req_bus.b_x, req_bus.b_y, req_bus.b_z};
            t.c[2] = '{req_bus.c_x, req_bus.c_y, req_bus.c_z};
            board.note_triangle(t);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            r.u         = '{rsp_bus.a_u, rsp_bus.b_u, rsp_bus.c_u};
            r.v         = '{rsp_bus.a_v, rsp_bus.b_v, rsp_bus.c_v};
            r.facing    = rsp_bus.facing;
            r.u_flipped = rsp_bus.u_flipped;
            board.check_uv(r);
         end
      end
   end

   // response side backpressure, the stall mode is redrawn at random
   initial begin
      int stall_mode;
      int mode_left;
      int tick;
      mode_left     = 0;
      tick          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold != 0) begin
            rsp_bus.ready = 1'b0;
            for (int k = 0; k < long_hold; k++)
               @(negedge clock);
            long_hold = 0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         tick++;
         case (stall_mode)
            0: rsp_bus.ready = 1'b1;
            1: rsp_bus.ready = 1'($urandom_range(0, 1));
            2: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready = (tick % 3 != 0);
         endcase
      end
   end

   function automatic triangle_type tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz);
      triangle_type t;
      t.c[0] = '{coord_type'(ax), coord_type'(ay), coord_type'(az)};
      t.c[1] = '{coord_type'(bx), coord_type'(by), coord_type'(bz)};
      t.c[2] = '{coord_type'(cx), coord_type'(cy), coord_type'(cz)};
      return t;
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int           kind;
      int           spread;
      int           axis;
      int           base[3];
      kind = $urandom_range(0, 9);
      if (kind <= 2 || kind == 9) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               t.c[i][k] = coord_type'($urandom());
      end else if (kind == 7) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               case ($urandom_range(0, 4))
                  0: t.c[i][k] = coord_type'(COORD_MIN);
                  1: t.c[i][k] = coord_type'(COORD_MAX);
                  2: t.c[i][k] = '0;
                  3: t.c[i][k] = '1;
                  default: t.c[i][k] = coord_type'(1);
               endcase
      end else begin
         // small spreads make ties and flat triangles likely
         case (kind)
            3, 4: spread = 5000;
            5: spread = 40;
            6: spread = 2;
            default: spread = 300;
         endcase
         for (int k = 0; k < 3; k++)
            base[k] = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               t.c[i][k] = coord_type'(base[k] + $signed($urandom_range(0, 2 * spread))
                                       - spread);
      end
      if (kind == 8) begin
         axis = $urandom_range(0, 2);
         t.c[1][axis] = t.c[0][axis];
         t.c[2][axis] = t.c[0][axis];
      end
      if (kind == 9)
         t.c[$urandom_range(1, 2)] = t.c[0];
      return t;
   endfunction

   task automatic send_triangle(triangle_type t);
      {req_bus.a_x, req_bus.a_y, req_bus.a_z} = {t.c[0][0], t.c[0][1], t.c[0][2]};
      {req_bus.b_x, req_bus.b_y, req_bus.b_z} = {t.c[1][0], t.c[1][1], t.c[1][2]};
      {req_bus.c_x, req_bus.c_y, req_bus.c_z} = {t.c[2][0], t.c[2][1], t.c[2][2]};
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      req_bus.valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (board.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [SCALE_WIDTH-1:0] value);
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      if (idx == CSR_INV_SCALE)
         board.inv_scale = value;
      else
         board.right_neg = value[0];
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   initial begin
      triangle_type           directed[$];
      logic [SCALE_WIDTH-1:0] scale;
      logic                   rneg;
      int                     burst_left;
      int                     k1;
      k1 = 2560;
      long_hold     = 0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      {req_bus.a_x, req_bus.a_y, req_bus.a_z} = '0;
      {req_bus.b_x, req_bus.b_y, req_bus.b_z} = '0;
      {req_bus.c_x, req_bus.c_y, req_bus.c_z} = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_INV_SCALE;
      csr_bus.data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // degenerate: zero, collinear, all max, all min
      directed = {directed, tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, tri_of(k1, k1, k1, 2*k1, 2*k1, 2*k1, 3*k1, 3*k1, 3*k1)};
      directed = {directed, tri_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)};
      directed = {directed, tri_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN)};
      // normal along +x, -x, +z, -z, +y, -y
      directed = {directed, tri_of(0, 0, 0, 0, k1, 0, 0, 0, k1)};
      directed = {directed, tri_of(0, 0, 0, 0, 0, k1, 0, k1, 0)};
      directed = {directed, tri_of(0, 0, 0, k1, 0, 0, 0, k1, 0)};
      directed = {directed, tri_of(0, 0, 0, 0, k1, 0, k1, 0, 0)};
      directed = {directed, tri_of(0, 0, 0, 0, 0, k1, k1, 0, 0)};
      directed = {directed, tri_of(0, 0, 0, k1, 0, 0, 0, 0, k1)};
      // ties: x with z, z with y, all three
      directed = {directed, tri_of(0, 0, 0, 0, k1, 0, k1, 0, k1)};
      directed = {directed, tri_of(0, 0, 0, -k1, 0, 0, 0, k1, k1)};
      directed = {directed, tri_of(0, 0, 0, k1, -k1, 0, 0, k1, -k1)};
      directed = {directed, tri_of(k1, k1, k1, 2*k1, 0, k1, k1, 2*k1, 0)};
      // flip set by right, then forward or up wins
      directed = {directed, tri_of(0, 0, 0, 0, k1, 0, -3*k1, 0, k1)};
      directed = {directed, tri_of(0, 0, 0, 0, 0, k1, 3*k1, -k1, 0)};
      // extreme coordinates, largest normals
      directed = {directed, tri_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                                   COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN)};
      directed = {directed, tri_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                   COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN)};
      directed = {directed, tri_of(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                   COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX)};
      directed = {directed, tri_of(-1, 1, -1, 1, -1, 1, -1, -1, 1)};
      directed = {directed, tri_of(-128, 127, 32767, -32768, -129, 128, 25, -25, -26)};

      foreach (directed[i]) begin
         send_triangle(directed[i]);
         if ($urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 4));
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin scale = INV_SCALE_RESET; rneg = 1'b0; end
            1: begin scale = '1;              rneg = 1'b1; end
            2: begin scale = 16'd1;           rneg = 1'b0; end
            3: begin scale = '0;              rneg = 1'b1; end
            4: begin scale = SCALE_WIDTH'($urandom_range(1, 65535)); rneg = 1'b0; end
            5: begin scale = '1;              rneg = 1'b0; end
            6: begin
               scale = SCALE_WIDTH'($urandom());
               rneg  = 1'($urandom_range(0, 1));
            end
            default: begin scale = INV_SCALE_RESET; rneg = RIGHT_NEG_RESET; end
         endcase
         write_register(CSR_INV_SCALE, scale);
         write_register(CSR_RIGHT_NEG, {15'($urandom_range(0, 2 ** 15 - 1)), rneg});
         // long response stall while requests keep coming
         if (p == 2 || p == 5)
            long_hold = 400;
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == PHASE_ITEMS / 2)
               wait_drained();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               pause_sender($urandom_range(0, 8));
            end
            burst_left--;
            send_triangle(random_triangle());
         end
      end

      wait_drained();
      repeat (3 * NUM_STAGES) @(negedge clock);
      if (board.errors == 0)
         $display("triangle_box_uv_projection_tb: clean");
      else
         $display("triangle_box_uv_projection_tb: errors");
      $finish;
   end

endmodule
